// File: sv/sfs_pkg.sv
`default_nettype none

package sfs_pkg;

  localparam int ELEMENT_DEPTH = 1024;
  localparam int FRAME_DEPTH   = 256;
  localparam int MAX_FRAME_LEN = 64;

  // Element index and count widths.
  localparam int EA_W   = $clog2(ELEMENT_DEPTH);
  localparam int CNT_W  = $clog2(ELEMENT_DEPTH + 1);
  // Frame index and count widths.
  localparam int FA_W   = $clog2(FRAME_DEPTH);
  localparam int FC_W   = $clog2(FRAME_DEPTH + 1);
  // Open frame length width.
  localparam int LEN_W  = $clog2(MAX_FRAME_LEN + 1);

  localparam int DATA_W = 32;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [1:0] ST_DATA     = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // One result slot issued by the controller; data results take their
  // element from the element RAM read, which is registered alongside the slot.
  typedef struct packed {
    logic       valid;
    logic       is_data;
    logic [1:0] status;
    logic       last;
  } iss_t;

  typedef struct packed {
    logic [DATA_W-1:0] element;
    logic [1:0]        status;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

// File: sv/sfs_ram.sv
`default_nettype none

module sfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: sv/sfs_out_buf.sv
`default_nettype none

module sfs_out_buf
  import sfs_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire res_t data_i,
  output      logic valid_o,
  input  wire logic ready_i,
  output      res_t data_o,
  output      logic [1:0] count_o,
  output      logic pop_o
);

  logic [1:0] count_q, count_d;
  res_t       ent0_q, ent1_q;
  logic       pop;
  logic [1:0] wsel;

  assign pop     = (count_q != 2'd0) && ready_i;
  assign wsel    = count_q - {1'b0, pop};
  assign valid_o = (count_q != 2'd0);
  assign data_o  = ent0_q;
  assign count_o = count_q;
  assign pop_o   = pop;

  always_comb begin
    count_d = count_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  // Entry 0 is the head; entry 1 acts as the skid slot.
  always_ff @(posedge clk_i) begin
    if (pop && (count_q == 2'd2)) begin
      ent0_q <= ent1_q;
    end
    if (push_i) begin
      if (wsel == 2'd0) begin
        ent0_q <= data_i;
      end else begin
        ent1_q <= data_i;
      end
    end
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && (count_q == 2'd2) && !pop))
    else $error("result buffer written while full");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("result buffer count out of range");

  a_hold_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !ready_i) |=> (valid_o && $stable(data_o)))
    else $error("stalled result changed before acceptance");

endmodule

`default_nettype wire

// File: sv/sfs_ctrl.sv
`default_nettype none

module sfs_ctrl
  import sfs_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire logic              opcode_i,
  input  wire logic [DATA_W-1:0] value_i,
  input  wire logic              close_i,
  input  wire logic [1:0]        buf_count_i,
  input  wire logic              buf_pop_i,
  output      logic              el_we_o,
  output      logic [EA_W-1:0]   el_waddr_o,
  output      logic [DATA_W-1:0] el_wdata_o,
  output      logic [EA_W-1:0]   el_raddr_o,
  output      logic              fs_we_o,
  output      logic [FA_W-1:0]   fs_waddr_o,
  output      logic [EA_W-1:0]   fs_wdata_o,
  output      logic [FA_W-1:0]   fs_raddr_o,
  input  wire logic [EA_W-1:0]   fs_rdata_i,
  output      iss_t              iss_o
);

  localparam int LENX_W = LEN_W + 1;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_FRAME  = 2'd1;
  localparam logic [1:0] S_STREAM = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] ec_q, ec_d;
  logic [FC_W-1:0]  fc_q, fc_d;
  logic [CNT_W-1:0] ofs_q, ofs_d;
  logic [LEN_W-1:0] olen_q, olen_d;
  logic [CNT_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0] end_q, end_d;
  iss_t             iss_q, iss_d;

  logic             credit_ok;
  logic             accept;
  logic             closing;
  logic             overflow;
  logic [CNT_W-1:0] start_raw;
  logic [CNT_W-1:0] start_lo;
  logic [CNT_W-1:0] start;
  logic [CNT_W-1:0] ptr_inc;

  // A result issued now passes the issue register before it lands in the buffer, so at most one slot
  // may be taken by the buffer and the issue register together, after any pop in this cycle.
  assign credit_ok = ({1'b0, buf_count_i} + {2'b00, iss_q.valid})
                     <= (3'd1 + {2'b00, buf_pop_i});
  assign in_ready_o = (state_q == S_IDLE) && credit_ok;
  assign accept     = in_valid_i && in_ready_o;

  assign closing  = close_i ||
                    (({1'b0, olen_q} + LENX_W'(1)) >= LENX_W'(MAX_FRAME_LEN));
  assign overflow = (ec_q >= CNT_W'(ELEMENT_DEPTH)) ||
                    (closing && (fc_q >= FC_W'(FRAME_DEPTH)));

  // Frame bounds from the frame-start RAM, clamped to the frame limit.
  assign start_raw = {{(CNT_W-EA_W){1'b0}}, fs_rdata_i};
  assign start_lo  = (start_raw > ofs_q) ? ofs_q : start_raw;
  assign start     = ((ofs_q - start_lo) > CNT_W'(MAX_FRAME_LEN))
                     ? (ofs_q - CNT_W'(MAX_FRAME_LEN)) : start_lo;
  assign ptr_inc   = ptr_q + CNT_W'(1);

  assign el_we_o    = accept && (opcode_i == OP_PUSH) && !overflow;
  assign el_waddr_o = ec_q[EA_W-1:0];
  assign el_wdata_o = value_i;
  assign el_raddr_o = ptr_q[EA_W-1:0];
  assign fs_we_o    = el_we_o && closing;
  assign fs_waddr_o = fc_q[FA_W-1:0];
  assign fs_wdata_o = ofs_q[EA_W-1:0];
  assign fs_raddr_o = FA_W'(fc_q - FC_W'(1));
  assign iss_o      = iss_q;

  always_comb begin
    state_d = state_q;
    ec_d    = ec_q;
    fc_d    = fc_q;
    ofs_d   = ofs_q;
    olen_d  = olen_q;
    ptr_d   = ptr_q;
    end_d   = end_q;
    iss_d   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (opcode_i == OP_PUSH) begin
            if (overflow) begin
              iss_d = '{valid: 1'b1, is_data: 1'b0, status: ST_OVERFLOW, last: 1'b1};
            end else begin
              ec_d = ec_q + CNT_W'(1);
              if (closing) begin
                fc_d   = fc_q + FC_W'(1);
                ofs_d  = ec_q + CNT_W'(1);
                olen_d = '0;
              end else begin
                olen_d = olen_q + LEN_W'(1);
              end
            end
          end else begin
            // The open frame is dropped before the top closed frame pops.
            ec_d   = ofs_q;
            olen_d = '0;
            if (fc_q == '0) begin
              iss_d = '{valid: 1'b1, is_data: 1'b0, status: ST_EMPTY, last: 1'b1};
            end else begin
              fc_d    = fc_q - FC_W'(1);
              state_d = S_FRAME;
            end
          end
        end
      end
      S_FRAME: begin
        if (credit_ok) begin
          end_d = ofs_q;
          ptr_d = start;
          ec_d  = start;
          ofs_d = start;
          if (start == ofs_q) begin
            iss_d   = '{valid: 1'b1, is_data: 1'b0, status: ST_EMPTY, last: 1'b1};
            state_d = S_IDLE;
          end else begin
            state_d = S_STREAM;
          end
        end
      end
      S_STREAM: begin
        if (credit_ok) begin
          ptr_d = ptr_inc;
          iss_d = '{valid: 1'b1, is_data: 1'b1, status: ST_DATA,
                    last: (ptr_inc == end_q)};
          if (ptr_inc == end_q) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ec_q    <= '0;
      fc_q    <= '0;
      ofs_q   <= '0;
      olen_q  <= '0;
      ptr_q   <= '0;
      end_q   <= '0;
      iss_q   <= '0;
    end else begin
      state_q <= state_d;
      ec_q    <= ec_d;
      fc_q    <= fc_d;
      ofs_q   <= ofs_d;
      olen_q  <= olen_d;
      ptr_q   <= ptr_d;
      end_q   <= end_d;
      iss_q   <= iss_d;
    end
  end

  a_count_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ec_q <= CNT_W'(ELEMENT_DEPTH)) && (fc_q <= FC_W'(FRAME_DEPTH)) && (ofs_q <= ec_q))
    else $error("stack counters out of range");

  a_stream_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STREAM) |-> (ptr_q < end_q))
    else $error("pop pointer ran past frame end");

  a_overflow_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (opcode_i == OP_PUSH) && overflow)
    |=> (iss_q.valid && (iss_q.status == ST_OVERFLOW) && !iss_q.is_data))
    else $error("dropped push gave no overflow result");

endmodule

`default_nettype wire

// File: sv/segmented_frame_stack.sv
// Pushes are taken one per cycle while the output buffer has room and give no result unless
// dropped for overflow. A pop reads the frame start, then the element RAM one element per
// cycle while the output buffer has room, and the input takes no new transaction until its last
// element is issued; elements reach the master side through the issue register and buffer.
// Reset empties the stack at once by clearing the counters; the RAMs are not cleared.
`default_nettype none

module segmented_frame_stack
  import sfs_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid_i,
  output      logic              s_axis_tready_o,
  input  wire logic [DATA_W-1:0] s_axis_tdata_i,  // [31:0] value
  input  wire logic              s_axis_tuser_i,  // [0] opcode
  input  wire logic              s_axis_tlast_i,
  output      logic              m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  output      logic [DATA_W-1:0] m_axis_tdata_o,  // [31:0] element
  output      logic [1:0]        m_axis_tuser_o,  // [1:0] status
  output      logic              m_axis_tlast_o
);

  logic              el_we;
  logic [EA_W-1:0]   el_waddr;
  logic [DATA_W-1:0] el_wdata;
  logic [EA_W-1:0]   el_raddr;
  logic [DATA_W-1:0] el_rdata;
  logic              fs_we;
  logic [FA_W-1:0]   fs_waddr;
  logic [EA_W-1:0]   fs_wdata;
  logic [FA_W-1:0]   fs_raddr;
  logic [EA_W-1:0]   fs_rdata;
  iss_t              iss;
  res_t              buf_in;
  res_t              buf_out;
  logic [1:0]        buf_count;
  logic              buf_pop;

  sfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .opcode_i    (s_axis_tuser_i),
    .value_i     (s_axis_tdata_i),
    .close_i     (s_axis_tlast_i),
    .buf_count_i (buf_count),
    .buf_pop_i   (buf_pop),
    .el_we_o     (el_we),
    .el_waddr_o  (el_waddr),
    .el_wdata_o  (el_wdata),
    .el_raddr_o  (el_raddr),
    .fs_we_o     (fs_we),
    .fs_waddr_o  (fs_waddr),
    .fs_wdata_o  (fs_wdata),
    .fs_raddr_o  (fs_raddr),
    .fs_rdata_i  (fs_rdata),
    .iss_o       (iss)
  );

  sfs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (ELEMENT_DEPTH)
  ) u_element_ram (
    .clk_i   (clk_i),
    .we_i    (el_we),
    .waddr_i (el_waddr),
    .wdata_i (el_wdata),
    .raddr_i (el_raddr),
    .rdata_o (el_rdata)
  );

  sfs_ram #(
    .WIDTH (EA_W),
    .DEPTH (FRAME_DEPTH)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (fs_we),
    .waddr_i (fs_waddr),
    .wdata_i (fs_wdata),
    .raddr_i (fs_raddr),
    .rdata_o (fs_rdata)
  );

  // Status results carry a zero element.
  assign buf_in = '{element: iss.is_data ? el_rdata : '0,
                    status:  iss.status,
                    last:    iss.last};

  sfs_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (iss.valid),
    .data_i  (buf_in),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (buf_out),
    .count_o (buf_count),
    .pop_o   (buf_pop)
  );

  assign m_axis_tdata_o = buf_out.element;
  assign m_axis_tuser_o = buf_out.status;
  assign m_axis_tlast_o = buf_out.last;

endmodule

`default_nettype wire

// File: dv/tb_segmented_frame_stack.sv
`timescale 1ns / 1ps

module tb_segmented_frame_stack;
  import sfs_pkg::*;

  localparam int RX_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES  = 16;
  localparam int MAX_REPORTS    = 10;
  localparam int RANDOM_ITEMS   = 48;
  localparam int DIR_ROWS       = 16;

  localparam res_t NO_RES    = '0;
  localparam res_t EMPTY_RES = '{element: '0, status: ST_EMPTY, last: 1'b1};
  localparam res_t OVF_RES   = '{element: '0, status: ST_OVERFLOW, last: 1'b1};

  typedef struct {
    logic              op;
    logic [DATA_W-1:0] value;
    logic              close;
    logic              typed;
    res_t              want;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata = '0;
  logic              s_tuser = 1'b0;
  logic              s_tlast = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;
  logic [1:0]        m_tuser;
  logic              m_tlast;

  // Sideband that travels with the driven transaction: a hand-typed expectation.
  logic drv_typed = 1'b0;
  res_t drv_want  = '0;

  bit no_idle     = 1'b0;
  int rx_hold_left = 0;

  // Predictor state.
  logic [DATA_W-1:0] model_elems [ELEMENT_DEPTH];
  logic [EA_W-1:0]   model_bases [FRAME_DEPTH];
  int unsigned       elem_cnt, frame_cnt, open_base, open_len;
  res_t              step_results [$];
  res_t              awaited [$];

  int n_items, n_pops, n_results, n_empty, n_overflow, n_fail;
  int longest_frame, peak_elems, peak_frames;

  // Directed rows; typed expectations only where they are obvious.
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{OP_POP,  32'h1234_5678, 1'b1, 1'b1, EMPTY_RES},
    '{OP_PUSH, 32'h7fff_ffff, 1'b1, 1'b0, NO_RES},
    '{OP_POP,  32'h0000_0000, 1'b0, 1'b1, '{32'h7fff_ffff, ST_DATA, 1'b1}},
    '{OP_PUSH, 32'h8000_0000, 1'b1, 1'b0, NO_RES},
    '{OP_POP,  32'hffff_ffff, 1'b1, 1'b1, '{32'h8000_0000, ST_DATA, 1'b1}},
    '{OP_PUSH, 32'h0000_0000, 1'b0, 1'b0, NO_RES},
    '{OP_PUSH, 32'hffff_ffff, 1'b0, 1'b0, NO_RES},
    '{OP_PUSH, 32'h0000_0005, 1'b1, 1'b0, NO_RES},
    '{OP_PUSH, 32'ha5a5_a5a5, 1'b0, 1'b0, NO_RES},
    '{OP_PUSH, 32'h5a5a_5a5a, 1'b1, 1'b0, NO_RES},
    '{OP_PUSH, 32'h0000_0001, 1'b0, 1'b0, NO_RES},
    '{OP_POP,  32'hdead_beef, 1'b0, 1'b0, NO_RES},
    '{OP_POP,  32'h0000_0000, 1'b1, 1'b0, NO_RES},
    '{OP_POP,  32'h0000_0000, 1'b0, 1'b1, EMPTY_RES},
    '{OP_PUSH, 32'h0000_0001, 1'b0, 1'b0, NO_RES},
    '{OP_POP,  32'h0000_0000, 1'b1, 1'b1, EMPTY_RES}
  };

  segmented_frame_stack u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .s_axis_tlast_i (s_tlast),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser),
    .m_axis_tlast_o (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void frame_stack_predict(input logic op, input logic [DATA_W-1:0] val,
                                              input logic close);
    logic        closing;
    int unsigned first, stop;
    step_results.delete();
    if (op == OP_PUSH) begin
      closing = close || (open_len + 1 >= MAX_FRAME_LEN);
      if (elem_cnt >= ELEMENT_DEPTH || (closing && frame_cnt >= FRAME_DEPTH)) begin
        step_results.push_back(OVF_RES);
        return;
      end
      model_elems[elem_cnt] = val;
      elem_cnt++;
      open_len++;
      if (closing) begin
        model_bases[frame_cnt] = open_base;
        frame_cnt++;
        open_base = elem_cnt;
        open_len  = 0;
      end
      if (elem_cnt > peak_elems) peak_elems = elem_cnt;
      if (frame_cnt > peak_frames) peak_frames = frame_cnt;
    end else begin
      // A pop first throws away whatever the open frame holds.
      elem_cnt = open_base;
      open_len = 0;
      if (frame_cnt == 0) begin
        step_results.push_back(EMPTY_RES);
        return;
      end
      frame_cnt--;
      first = model_bases[frame_cnt];
      stop  = elem_cnt;
      for (int unsigned i = first; i < stop; i++)
        step_results.push_back('{model_elems[i], ST_DATA, (i + 1 == stop)});
      if (stop - first > longest_frame) longest_frame = stop - first;
      elem_cnt  = first;
      open_base = first;
    end
  endfunction

  task automatic check_result(input res_t got);
    res_t want;
    n_results++;
    if (got.status == ST_EMPTY) n_empty++;
    if (got.status == ST_OVERFLOW) n_overflow++;
    if (awaited.size() == 0) begin
      n_fail++;
      if (n_fail <= MAX_REPORTS)
        $display("%0t: unexpected result element %h status %0d last %0b",
                 $realtime, got.element, got.status, got.last);
      return;
    end
    want = awaited.pop_front();
    if (got.element !== want.element || got.status !== want.status ||
        got.last !== want.last) begin
      n_fail++;
      if (n_fail <= MAX_REPORTS)
        $display("%0t: mismatch: expected element %h status %0d last %0b, got %h %0d %0b",
                 $realtime, want.element, want.status, want.last,
                 got.element, got.status, got.last);
    end
  endtask

  // Results are checked before the transaction accepted at the same edge is predicted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (m_tvalid && m_tready) check_result('{m_tdata, m_tuser, m_tlast});
      if (s_tvalid && s_tready) begin
        n_items++;
        if (s_tuser == OP_POP) n_pops++;
        frame_stack_predict(s_tuser, s_tdata, s_tlast);
        if (drv_typed) awaited.push_back(drv_want);
        else foreach (step_results[k]) awaited.push_back(step_results[k]);
      end
    end
  end

  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      m_tready <= 1'b0;
      rx_hold_left--;
    end else if (no_idle) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= 14);
    end
  end

  // Called and left at a falling edge.
  task automatic offer(input logic op, input logic [DATA_W-1:0] val, input logic close,
                       input logic typed = 1'b0, input res_t want = '0);
    while (!no_idle && $urandom_range(99) < 14) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid  <= 1'b1;
    s_tdata   <= val;
    s_tuser   <= op;
    s_tlast   <= close;
    drv_typed <= typed;
    drv_want  <= want;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_results_done;
    s_tvalid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_tab[r])
      offer(dir_tab[r].op, dir_tab[r].value, dir_tab[r].close, dir_tab[r].typed,
            dir_tab[r].want);
    wait_results_done();

    // Stall the output for a long while; a frame that reaches the length limit closes
    // without the last flag, and its pop backs up into the input.
    @(posedge clk);
    rx_hold_left = RX_HOLD_CYCLES;
    @(negedge clk);
    for (int k = 0; k < MAX_FRAME_LEN; k++) offer(OP_PUSH, $urandom, 1'b0);
    offer(OP_PUSH, $urandom, 1'b0);
    offer(OP_POP, $urandom, 1'b0);
    offer(OP_POP, $urandom, 1'b0, 1'b1, EMPTY_RES);
    wait_results_done();

    // Random traffic at full rate on both sides, then with idling.
    @(posedge clk);
    no_idle = 1'b1;
    @(negedge clk);
    for (int n = 0; n < RANDOM_ITEMS / 2; n++) begin
      if ($urandom_range(3) == 0) offer(OP_POP, $urandom, $urandom_range(1));
      else offer(OP_PUSH, $urandom, $urandom_range(2) == 0);
    end
    wait_results_done();
    @(posedge clk);
    no_idle = 1'b0;
    @(negedge clk);

    for (int n = RANDOM_ITEMS / 2; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(3) == 0) offer(OP_POP, $urandom, $urandom_range(1));
      else offer(OP_PUSH, $urandom, $urandom_range(2) == 0);
    end
    wait_results_done();

    $display("Covered %0d transactions (%0d pops), %0d results: %0d empty, %0d overflow.",
             n_items, n_pops, n_results, n_empty, n_overflow);
    $display("Longest frame popped %0d elements; stack peaked at %0d elements, %0d frames.",
             longest_frame, peak_elems, peak_frames);
    if (n_fail == 0) begin
      $display("segmented_frame_stack regression: pass");
    end else begin
      $display("%0d failures", n_fail);
      $display("segmented_frame_stack regression: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", awaited.size());
    $display("segmented_frame_stack regression: fail");
    $finish;
  end

endmodule
